>>> hdl/rks_pkg.sv
// Shared constants, command codes and status bundle for the range k-th
// smallest block. No dependencies.
package rks_pkg;

  localparam int ADDR_W = 14;                 // element index
  localparam int NUM_ELEMENTS = 1 << ADDR_W;
  localparam int IDX_W = 7;                   // position inside a block
  localparam int BLOCK_SIZE = 1 << IDX_W;
  localparam int BLK_W = ADDR_W - IDX_W;      // block number
  localparam int VAL_W = 31;
  localparam int CNT_W = ADDR_W + 1;
  localparam int BIT_W = 5;
  localparam int LOHI_W = IDX_W + 1;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef logic [4:0] cmd_t;
  localparam cmd_t CMD_NONE      = 5'd0;
  localparam cmd_t CMD_LOAD      = 5'd1;
  localparam cmd_t CMD_CLR       = 5'd2;
  localparam cmd_t CMD_RD_OLD    = 5'd3;
  localparam cmd_t CMD_BS_UINIT  = 5'd4;
  localparam cmd_t CMD_BS_RD     = 5'd5;
  localparam cmd_t CMD_BS_CMP    = 5'd6;
  localparam cmd_t CMD_CLAMP     = 5'd7;
  localparam cmd_t CMD_DN_RD     = 5'd8;
  localparam cmd_t CMD_DN_CMP    = 5'd9;
  localparam cmd_t CMD_UP_RD     = 5'd10;
  localparam cmd_t CMD_UP_CMP    = 5'd11;
  localparam cmd_t CMD_UPD_WR    = 5'd12;
  localparam cmd_t CMD_PASS_INIT = 5'd13;
  localparam cmd_t CMD_BLK       = 5'd14;
  localparam cmd_t CMD_SC_RD     = 5'd15;
  localparam cmd_t CMD_SC_CMP    = 5'd16;
  localparam cmd_t CMD_BS_ADD    = 5'd17;
  localparam cmd_t CMD_DECIDE    = 5'd18;
  localparam cmd_t CMD_OUT       = 5'd19;

  typedef struct packed {
    logic is_query;
    logic clr_last;
    logic bs_done;
    logic i_zero;
    logic i_top;
    logic dn_move;
    logic up_move;
    logic empty;
    logic p_past;
    logic whole;
    logic scan_last;
    logic bit_zero;
  } stat_t;

endpackage

>>> hdl/range_kth_smallest_with_updates.sv
// Top level: range k-th smallest with point updates.
// Depends on rks_pkg, rks_ctrl, rks_datapath.
//
// Usage: present in_func/in_left/in_right/in_value with start; the beat is
// taken on an edge where start is high and busy is low.
// Update (in_func=0): writes in_value at in_left and re-sorts that block's
//   copy by moving neighbors one slot at a time, each move a registered
//   read of the sorted-copy memory and a compare. No result.
// Query (in_func=1): one out_valid pulse carrying out_kth_value, the
//   in_value-th smallest of positions in_left..in_right (all ones if the rank
//   exceeds the range, zero for rank zero). 31 counting passes; each pass
//   scans the edge blocks element by element and counts each whole block
//   by a 7- or 8-step binary search of its sorted copy.
// Results are held for exactly one cycle; the receiver cannot stall.
// After reset, busy stays high while both memories are
// cleared to zero, one entry per cycle.
module range_kth_smallest_with_updates (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [13:0] in_left,
  input  logic [13:0] in_right,
  input  logic [30:0] in_value,
  output logic [30:0] out_kth_value,
  output logic        out_valid
);
  import rks_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rks_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_func(in_func),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  rks_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_func(in_func),
    .in_left(in_left), .in_right(in_right), .in_value(in_value),
    .stat(stat), .out_kth_value(out_kth_value), .out_valid(out_valid)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> busy) else $error("clear pass not running after reset");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a beat");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a query in flight");
endmodule

>>> hdl/rks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/rks_datapath.sv
// Datapath: element store, sorted block copies, search and count registers.
// Depends on rks_pkg and rks_ram.
module rks_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rks_pkg::cmd_t         cmd,
  input  logic                  in_func,
  input  logic [13:0]           in_left,
  input  logic [13:0]           in_right,
  input  logic [30:0]           in_value,
  output rks_pkg::stat_t        stat,
  output logic [30:0]           out_kth_value,
  output logic                  out_valid
);
  import rks_pkg::*;

  logic              func_r;
  logic [ADDR_W-1:0] pos_r, right_r, q_r, stop_r, clr_r;
  logic [CNT_W-1:0]  p_r, cnt_r;
  logic [VAL_W-1:0]  val_r, res_r, cand_r, x_r, kth_r;
  logic [BIT_W-1:0]  bit_r;
  logic [LOHI_W-1:0] lo_r, hi_r;
  logic [IDX_W-1:0]  i_r;
  logic [BLK_W-1:0]  blk_r;
  logic              valid_r;

  logic [VAL_W-1:0]  e_rdata, s_rdata;
  logic              e_we, s_we;
  logic [ADDR_W-1:0] e_waddr, e_raddr, s_waddr, s_raddr;
  logic [VAL_W-1:0]  e_wdata, s_wdata;
  logic [LOHI_W-1:0] lohi_sum;
  logic [IDX_W-1:0]  mid, s_idx;
  logic [ADDR_W-1:0] p_bend;
  logic [CNT_W-1:0]  next_blk;
  logic              whole;

  assign lohi_sum = lo_r + hi_r;
  assign mid      = lohi_sum[LOHI_W-1:1];
  assign p_bend   = {p_r[ADDR_W-1:IDX_W], {IDX_W{1'b1}}};
  assign whole    = (p_r[IDX_W-1:0] == '0) && (p_bend <= right_r);
  assign next_blk = {1'b0, blk_r, {IDX_W{1'b0}}} + CNT_W'(BLOCK_SIZE);

  always_comb begin
    stat.is_query  = (func_r == FUNC_QUERY);
    stat.clr_last  = (clr_r == {ADDR_W{1'b1}});
    stat.bs_done   = (lo_r >= hi_r);
    stat.i_zero    = (i_r == '0);
    stat.i_top     = (i_r == {IDX_W{1'b1}});
    stat.dn_move   = (s_rdata > val_r);
    stat.up_move   = (s_rdata < val_r);
    stat.empty     = (pos_r > right_r);
    stat.p_past    = (p_r > {1'b0, right_r});
    stat.whole     = whole;
    stat.scan_last = (q_r == stop_r);
    stat.bit_zero  = (bit_r == '0);
  end

  always_comb begin
    case (cmd)
      CMD_BS_RD: s_idx = mid;
      CMD_DN_RD: s_idx = i_r - IDX_W'(1);
      default:   s_idx = i_r + IDX_W'(1);
    endcase
  end

  assign e_we    = (cmd == CMD_CLR) || (cmd == CMD_UPD_WR);
  assign e_waddr = (cmd == CMD_CLR) ? clr_r : pos_r;
  assign e_wdata = (cmd == CMD_CLR) ? '0 : val_r;
  assign e_raddr = (cmd == CMD_SC_RD) ? q_r : pos_r;

  assign s_we = (cmd == CMD_CLR) || (cmd == CMD_UPD_WR)
             || ((cmd == CMD_DN_CMP) && stat.dn_move)
             || ((cmd == CMD_UP_CMP) && stat.up_move);
  assign s_waddr = (cmd == CMD_CLR) ? clr_r : {blk_r, i_r};
  assign s_wdata = (cmd == CMD_CLR) ? '0 : ((cmd == CMD_UPD_WR) ? val_r : s_rdata);
  assign s_raddr = {blk_r, s_idx};

  rks_ram #(.WIDTH(VAL_W), .DEPTH(NUM_ELEMENTS)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  rks_ram #(.WIDTH(VAL_W), .DEPTH(NUM_ELEMENTS)) u_sorted (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= (cmd == CMD_OUT);
      if (cmd == CMD_CLR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        func_r  <= in_func;
        pos_r   <= in_left;
        right_r <= in_right;
        val_r   <= in_value;
        res_r   <= '0;
        bit_r   <= BIT_W'(VAL_W - 1);
      end
      CMD_BS_UINIT: begin
        x_r   <= e_rdata;
        lo_r  <= '0;
        hi_r  <= LOHI_W'(BLOCK_SIZE);
        blk_r <= pos_r[ADDR_W-1:IDX_W];
      end
      CMD_BS_CMP: begin
        if (s_rdata < x_r) begin
          lo_r <= {1'b0, mid} + LOHI_W'(1);
        end else begin
          hi_r <= {1'b0, mid};
        end
      end
      CMD_CLAMP: i_r <= lo_r[IDX_W] ? {IDX_W{1'b1}} : lo_r[IDX_W-1:0];
      CMD_DN_CMP: if (stat.dn_move) i_r <= i_r - IDX_W'(1);
      CMD_UP_CMP: if (stat.up_move) i_r <= i_r + IDX_W'(1);
      CMD_PASS_INIT: begin
        cand_r <= res_r | (VAL_W'(1) << bit_r);
        cnt_r  <= '0;
        p_r    <= {1'b0, pos_r};
      end
      CMD_BLK: begin
        blk_r  <= p_r[ADDR_W-1:IDX_W];
        x_r    <= cand_r;
        lo_r   <= '0;
        hi_r   <= LOHI_W'(BLOCK_SIZE);
        q_r    <= p_r[ADDR_W-1:0];
        stop_r <= (p_bend < right_r) ? p_bend : right_r;
      end
      CMD_SC_CMP: begin
        cnt_r <= cnt_r + CNT_W'(e_rdata < cand_r);
        q_r   <= q_r + ADDR_W'(1);
        if (q_r == stop_r) begin
          p_r <= next_blk;
        end
      end
      CMD_BS_ADD: begin
        cnt_r <= cnt_r + CNT_W'(lo_r);
        p_r   <= next_blk;
      end
      CMD_DECIDE: begin
        if ({{(VAL_W-CNT_W){1'b0}}, cnt_r} < val_r) begin
          res_r <= cand_r;
        end
        bit_r <= bit_r - BIT_W'(1);
      end
      CMD_OUT: kth_r <= res_r;
      default: ;
    endcase
  end

  assign out_kth_value = kth_r;
  assign out_valid     = valid_r;
endmodule

>>> hdl/rks_ctrl.sv
// Sequencer for clear pass, update insertion and bitwise query search.
// Depends on rks_pkg.
module rks_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            in_func,
  input  rks_pkg::stat_t  stat,
  output rks_pkg::cmd_t   cmd,
  output logic            busy
);
  import rks_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_U_RD   = 5'd2;
  localparam logic [4:0] S_U_INIT = 5'd3;
  localparam logic [4:0] S_BS_RD  = 5'd4;
  localparam logic [4:0] S_BS_CMP = 5'd5;
  localparam logic [4:0] S_CLAMP  = 5'd6;
  localparam logic [4:0] S_DN_RD  = 5'd7;
  localparam logic [4:0] S_DN_CMP = 5'd8;
  localparam logic [4:0] S_UP_RD  = 5'd9;
  localparam logic [4:0] S_UP_CMP = 5'd10;
  localparam logic [4:0] S_U_WR   = 5'd11;
  localparam logic [4:0] S_Q_PASS = 5'd12;
  localparam logic [4:0] S_Q_BLK  = 5'd13;
  localparam logic [4:0] S_SC_RD  = 5'd14;
  localparam logic [4:0] S_SC_CMP = 5'd15;
  localparam logic [4:0] S_Q_ADD  = 5'd16;
  localparam logic [4:0] S_Q_DEC  = 5'd17;
  localparam logic [4:0] S_Q_OUT  = 5'd18;

  logic [4:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_CLR: begin
        cmd = CMD_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = (in_func == FUNC_QUERY) ? S_Q_PASS : S_U_RD;
        end
      end
      S_U_RD: begin
        cmd       = CMD_RD_OLD;
        state_nxt = S_U_INIT;
      end
      S_U_INIT: begin
        cmd       = CMD_BS_UINIT;
        state_nxt = S_BS_RD;
      end
      S_BS_RD: begin
        if (stat.bs_done) begin
          state_nxt = stat.is_query ? S_Q_ADD : S_CLAMP;
        end else begin
          cmd       = CMD_BS_RD;
          state_nxt = S_BS_CMP;
        end
      end
      S_BS_CMP: begin
        cmd       = CMD_BS_CMP;
        state_nxt = S_BS_RD;
      end
      S_CLAMP: begin
        cmd       = CMD_CLAMP;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.i_zero) begin
          state_nxt = S_UP_RD;
        end else begin
          cmd       = CMD_DN_RD;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd       = CMD_DN_CMP;
        state_nxt = stat.dn_move ? S_DN_RD : S_UP_RD;
      end
      S_UP_RD: begin
        if (stat.i_top) begin
          state_nxt = S_U_WR;
        end else begin
          cmd       = CMD_UP_RD;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd       = CMD_UP_CMP;
        state_nxt = stat.up_move ? S_UP_RD : S_U_WR;
      end
      S_U_WR: begin
        cmd       = CMD_UPD_WR;
        state_nxt = S_IDLE;
      end
      S_Q_PASS: begin
        cmd       = CMD_PASS_INIT;
        state_nxt = stat.empty ? S_Q_DEC : S_Q_BLK;
      end
      S_Q_BLK: begin
        if (stat.p_past) begin
          state_nxt = S_Q_DEC;
        end else begin
          cmd       = CMD_BLK;
          state_nxt = stat.whole ? S_BS_RD : S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd       = CMD_SC_RD;
        state_nxt = S_SC_CMP;
      end
      S_SC_CMP: begin
        cmd       = CMD_SC_CMP;
        state_nxt = stat.scan_last ? S_Q_BLK : S_SC_RD;
      end
      S_Q_ADD: begin
        cmd       = CMD_BS_ADD;
        state_nxt = S_Q_BLK;
      end
      S_Q_DEC: begin
        cmd       = CMD_DECIDE;
        state_nxt = stat.bit_zero ? S_Q_OUT : S_Q_PASS;
      end
      S_Q_OUT: begin
        cmd       = CMD_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
